### hdl/brwn_pkg.sv
// Shared constants for the biased random walk noise generator.
package brwn_pkg;

  localparam int BIAS_RANGE_DEF  = 128;
  localparam int CLIP_STRIDE_DEF = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CHANGE_W = 16;
  localparam int RAND_W   = 31;
  localparam int LEN_W    = 24;
  localparam int OUT_W    = 16;
  localparam int IN_W     = 2 * CHANGE_W + 2 * RAND_W;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

  localparam logic [LEN_W-1:0] NOISE_LENGTH_RESET = LEN_W'(65536);

endpackage

### hdl/biased_random_walk_noise.sv
// Top level of the biased random walk noise generator.
// A sample is loaded into the output register once both bit-serial remainder units are done
// and the register is free. A new input beat is accepted only after the previous one is done.
// A finished sample waits in the output register while the next beat is already being worked.
// Reset (rst, synchronous) sets level to zero, bias to half the range minus one,
// the sample count to zero and the length register to 65536.
module biased_random_walk_noise import brwn_pkg::*; #(
  parameter int BIAS_RANGE  = BIAS_RANGE_DEF,
  parameter int CLIP_STRIDE = CLIP_STRIDE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // min_change[15:0], max_change[31:16], rand_direction[62:32], rand_magnitude[93:63]
  input  logic [IN_TDATA_W-1:0] s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // sample_out[15:0]
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LEN_W-1:0]      cfg_data
);

  localparam int BW  = $clog2(BIAS_RANGE);
  localparam int DW  = $clog2(BIAS_RANGE + 1);
  localparam int XW  = $clog2(BIAS_RANGE + CLIP_STRIDE) + 2;
  localparam int STW = CHANGE_W + 1;
  localparam int SW  = (SAMPLE_BITS > STW ? SAMPLE_BITS : STW) + 2;

  localparam logic [BW-1:0] BIAS_RESET = BW'((BIAS_RANGE >> 1) - 1);
  localparam logic [DW-1:0] RANGE_DIV  = DW'(BIAS_RANGE);
  localparam logic signed [XW-1:0] R_X = XW'(BIAS_RANGE);
  localparam logic signed [XW-1:0] S_X = XW'(CLIP_STRIDE);
  localparam logic signed [SW-1:0] LEVEL_MAX = SW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] LEVEL_MIN = -LEVEL_MAX - SW'(1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  logic [LEN_W-1:0]             noise_length;
  logic signed [SAMPLE_BITS-1:0] level, level_next;
  logic [BW-1:0]                bias, bias_next;
  logic [LEN_W-1:0]             position, position_next;
  logic [CHANGE_W-1:0]          lo;

  logic                accept;
  logic [CHANGE_W-1:0] min_in, max_in;
  logic [RAND_W-1:0]   dir_in, mag_in;
  logic [CHANGE_W:0]   span;
  logic [CHANGE_W-1:0] diff;
  logic                dir_done, mag_done;
  logic [DW-1:0]       draw;
  logic [CHANGE_W-1:0] mag_rem;
  logic                active, load_out;

  logic [STW-1:0]        step;
  logic                  up;
  logic signed [SW-1:0]  sum;
  logic signed [XW-1:0]  bx;
  logic signed [SAMPLE_BITS+OUT_W-1:0] level_ext;

  assign min_in = s_tdata[CHANGE_W-1:0];
  assign max_in = s_tdata[2*CHANGE_W-1:CHANGE_W];
  assign dir_in = s_tdata[2*CHANGE_W+RAND_W-1:2*CHANGE_W];
  assign mag_in = s_tdata[2*CHANGE_W+2*RAND_W-1:2*CHANGE_W+RAND_W];

  assign span = {1'b0, max_in} - {1'b0, min_in};
  assign diff = (span[CHANGE_W] || span == '0) ? CHANGE_W'(1) : span[CHANGE_W-1:0];

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  brwn_serial_mod #(.DIVIDEND_W(RAND_W), .DIVISOR_W(DW)) u_dir_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (dir_in),
    .divisor   (RANGE_DIV),
    .done      (dir_done),
    .remainder (draw)
  );

  brwn_serial_mod #(.DIVIDEND_W(RAND_W), .DIVISOR_W(CHANGE_W)) u_mag_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (mag_in),
    .divisor   (diff),
    .done      (mag_done),
    .remainder (mag_rem)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      lo <= min_in;
    end
  end

  assign active   = (position < noise_length);
  assign load_out = (state == ST_FINISH) && active && (!m_tvalid || m_tready);

  always_comb begin
    step = STW'(lo) + STW'(mag_rem);
    up   = (draw > DW'(bias));
    bx   = XW'(bias);
    if (up) begin
      sum = SW'(level) + SW'(step);
    end else begin
      sum = SW'(level) - SW'(step);
    end
    if (up) begin
      if (sum > LEVEL_MAX) begin
        sum = LEVEL_MAX;
        if (bx < R_X - S_X) begin
          bx = bx + S_X;
        end else begin
          bx = R_X - XW'(1);
        end
      end
      if (bx < R_X - XW'(1)) begin
        bx = bx + XW'(1);
      end
    end else begin
      if (sum < LEVEL_MIN) begin
        sum = LEVEL_MIN;
        if (bx > S_X - XW'(1)) begin
          bx = bx - S_X;
        end else begin
          bx = '0;
        end
      end
      if (bx > XW'(0)) begin
        bx = bx - XW'(1);
      end
    end
    level_next    = sum[SAMPLE_BITS-1:0];
    bias_next     = bx[BW-1:0];
    position_next = position + LEN_W'(1);
  end

  assign level_ext = (SAMPLE_BITS + OUT_W)'(level_next);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (dir_done && mag_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!active || load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      noise_length <= NOISE_LENGTH_RESET;
      level        <= '0;
      bias         <= BIAS_RESET;
      position     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        noise_length <= cfg_data;
      end
      if (load_out) begin
        level    <= level_next;
        bias     <= bias_next;
        position <= position_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= level_ext[OUT_W-1:0];
      m_tlast <= (position_next == noise_length);
    end
  end

endmodule

### hdl/brwn_serial_mod.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module brwn_serial_mod import brwn_pkg::*; #(
  parameter int DIVIDEND_W = RAND_W,
  parameter int DIVISOR_W  = CHANGE_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] shreg;
  logic [DIVISOR_W-1:0]  div;
  logic [DIVISOR_W-1:0]  rem;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;

  assign trial = {rem, shreg[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DIVIDEND_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      div   <= divisor;
      rem   <= '0;
    end else if (cnt != '0) begin
      shreg <= {shreg[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, div}) begin
        rem <= diff[DIVISOR_W-1:0];
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
    end
  end

  assign done      = (cnt == '0);
  assign remainder = rem;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the biased random walk noise generator.
`timescale 1ns / 100ps

module tb_top;
  import brwn_pkg::*;

  localparam longint LEVEL_MAX = (longint'(1) <<< (SAMPLE_BITS_DEF - 1)) - 1;
  localparam longint LEVEL_MIN = -LEVEL_MAX - 1;
  localparam logic [RAND_W-1:0] RAND_ONES = '1;
  localparam logic TYPED = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam int DIR_ROWS = 21;
  localparam int RANDOM_GOAL = 570;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT = 200;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [CHANGE_W-1:0] minc;
    logic [CHANGE_W-1:0] maxc;
    logic [RAND_W-1:0]   rdir;
    logic [RAND_W-1:0]   rmag;
    logic                typed;
    logic [OUT_W-1:0]    t_sample;
    logic                t_last;
  } stim_row_t;

  typedef struct packed {
    logic [OUT_W-1:0] sample;
    logic             last;
  } noise_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LEN_W-1:0]      cfg_data = '0;

  longint           walk_level = 0;
  int               walk_bias = (BIAS_RANGE_DEF >> 1) - 1;
  logic [LEN_W-1:0] walk_pos = '0;
  logic [LEN_W-1:0] walk_len = NOISE_LENGTH_RESET;

  noise_beat_t sample_q[$];
  int beats_sent = 0;
  int samples_due = 0;
  int samples_checked = 0;
  int length_writes = 0;
  int up_clips = 0;
  int down_clips = 0;
  int errors = 0;
  bit sender_quiet = 1'b0;
  bit receiver_quiet = 1'b0;
  bit held = 1'b0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{16'd0,     16'd0,     31'd0,         31'd0,      TYPED,     16'h0000, 1'b0},
    '{16'd0,     16'hFFFF,  RAND_ONES,     RAND_ONES,  PREDICTED, 16'h0000, 1'b0},
    '{16'hFFFF,  16'd0,     RAND_ONES,     RAND_ONES,  TYPED,     16'h7FFF, 1'b0},
    '{16'hFFFF,  16'd0,     RAND_ONES,     RAND_ONES,  TYPED,     16'h7FFF, 1'b0},
    '{16'hFFFF,  16'd0,     RAND_ONES,     RAND_ONES,  TYPED,     16'h7FFF, 1'b0},
    '{16'hFFFF,  16'd0,     RAND_ONES,     RAND_ONES,  TYPED,     16'h7FFF, 1'b0},
    '{16'hFFFF,  16'd0,     RAND_ONES,     RAND_ONES,  PREDICTED, 16'h0000, 1'b0},
    '{16'hFFFF,  16'hFFFF,  31'd0,         31'd0,      TYPED,     16'h8000, 1'b0},
    '{16'hFFFF,  16'hFFFF,  31'd0,         31'd0,      TYPED,     16'h8000, 1'b0},
    '{16'hFFFF,  16'hFFFF,  31'd0,         31'd0,      TYPED,     16'h8000, 1'b0},
    '{16'hFFFF,  16'hFFFF,  31'd0,         31'd0,      TYPED,     16'h8000, 1'b0},
    '{16'hFFFF,  16'hFFFF,  31'd0,         31'd0,      TYPED,     16'h8000, 1'b0},
    '{16'hFFFF,  16'hFFFF,  31'd0,         31'd0,      TYPED,     16'h8000, 1'b0},
    '{16'hFFFF,  16'hFFFF,  31'd0,         31'd0,      TYPED,     16'h8000, 1'b0},
    '{16'hFFFF,  16'hFFFF,  31'd0,         31'd0,      TYPED,     16'h8000, 1'b0},
    '{16'd0,     16'd1,     31'd0,         RAND_ONES,  TYPED,     16'h8000, 1'b0},
    '{16'd100,   16'd200,   31'd1,         31'd12345,  PREDICTED, 16'h0000, 1'b0},
    '{16'd0,     16'd50,    31'h7FFFFF80,  31'd77,     PREDICTED, 16'h0000, 1'b0},
    '{16'h5555,  16'hAAAA,  31'h2AAAAAAA,  31'h55555555, PREDICTED, 16'h0000, 1'b0},
    '{16'hAAAA,  16'h5555,  31'h55555555,  31'h2AAAAAAA, PREDICTED, 16'h0000, 1'b0},
    '{16'd1000,  16'd1000,  31'd64,        31'd999,    PREDICTED, 16'h0000, 1'b0}
  };

  biased_random_walk_noise dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit walk_step(input stim_row_t row, output noise_beat_t beat);
    longint span;
    longint step;
    longint draw;
    beat = '0;
    if (walk_pos >= walk_len) return 1'b0;
    span = longint'(row.maxc) - longint'(row.minc);
    if (span < 1) span = 1;
    draw = longint'(row.rdir) % BIAS_RANGE_DEF;
    step = longint'(row.minc) + longint'(row.rmag) % span;
    if (draw > walk_bias) begin
      walk_level = walk_level + step;
      if (walk_level > LEVEL_MAX) begin
        walk_level = LEVEL_MAX;
        up_clips++;
        if (walk_bias < BIAS_RANGE_DEF - CLIP_STRIDE_DEF) walk_bias += CLIP_STRIDE_DEF;
        else walk_bias = BIAS_RANGE_DEF - 1;
      end
      if (walk_bias < BIAS_RANGE_DEF - 1) walk_bias++;
    end else begin
      walk_level = walk_level - step;
      if (walk_level < LEVEL_MIN) begin
        walk_level = LEVEL_MIN;
        down_clips++;
        if (walk_bias > CLIP_STRIDE_DEF - 1) walk_bias -= CLIP_STRIDE_DEF;
        else walk_bias = 0;
      end
      if (walk_bias > 0) walk_bias--;
    end
    walk_pos = walk_pos + 1'b1;
    beat.sample = walk_level[OUT_W-1:0];
    beat.last = (walk_pos == walk_len);
    return 1'b1;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t row;
    row = '0;
    row.typed = PREDICTED;
    row.rdir = RAND_W'($urandom);
    row.rmag = RAND_W'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      row.minc = CHANGE_W'($urandom_range(0, 1500));
      row.maxc = row.minc + CHANGE_W'($urandom_range(0, 2500));
    end else begin
      row.minc = CHANGE_W'($urandom);
      row.maxc = CHANGE_W'($urandom);
    end
    return row;
  endfunction

  task automatic send_item(input stim_row_t row);
    int gap;
    noise_beat_t beat;
    if (beats_sent % 40 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
    gap = sender_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, row.rmag, row.rdir, row.maxc, row.minc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    if (walk_step(row, beat)) begin
      samples_due++;
      if (row.typed) sample_q.push_back({row.t_sample, row.t_last});
      else sample_q.push_back(beat);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    walk_len = value;
    length_writes++;
  endtask

  initial begin
    int gap;
    noise_beat_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (samples_checked % 50 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
      gap = receiver_quiet ? 0 : $urandom_range(0, 11);
      if (samples_checked == HOLD_AT && !held) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      samples_checked++;
      if (sample_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample beat, expected none, got %h last %b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = sample_q.pop_front();
        if (m_tdata !== want.sample) begin
          errors++;
          $display("%0t: sample mismatch, expected %h, got %h", $time, want.sample, m_tdata);
        end
        if (m_tlast !== want.last) begin
          errors++;
          $display("%0t: last flag mismatch, expected %b, got %b", $time, want.last, m_tlast);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d samples outstanding", $time, sample_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int n;
    int goal;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) send_item(dir_rows[i]);
    settle();

    write_length(walk_pos + LEN_W'(3));
    repeat (5) send_item(random_row());
    settle();
    write_length('0);
    repeat (3) send_item(random_row());
    settle();
    write_length('1);

    goal = beats_sent + RANDOM_GOAL;
    while (beats_sent < goal) begin
      n = $urandom_range(10, 100);
      if (n > goal - beats_sent) n = goal - beats_sent;
      repeat (n) send_item(random_row());
      settle();
      case ($urandom_range(0, 9))
        0: write_length(LEN_W'($urandom_range(0, int'(walk_pos))));
        1: write_length('1);
        default: write_length(walk_pos + LEN_W'($urandom_range(1, 80)));
      endcase
    end
    settle();

    $display("Sent %0d input beats and checked %0d samples across %0d length settings.",
             beats_sent, samples_checked, length_writes);
    $display("The walk clipped %0d times at the top and %0d times at the bottom.",
             up_clips, down_clips);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
